@@ sv/zad_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the z-score anomaly detector.
// No dependencies; every other file imports this package.
package zad_pkg;

  localparam int WINDOW_DEPTH_DEF = 128;
  localparam int SAMPLE_BITS_DEF  = 16;

  // multiplier digit width, bits consumed per step of the serial multiplier
  localparam int DIG_W   = 16;
  localparam int THR_W   = 16;
  localparam int HELD_W  = 8;
  // Q8.8 threshold squared carries 16 fraction bits
  localparam int FRAC_SH = 16;

  localparam logic [THR_W-1:0]   THR_DEFAULT = 16'd768;
  localparam logic [2*THR_W-1:0] T2_DEFAULT  =
    (2*THR_W)'(THR_DEFAULT) * (2*THR_W)'(THR_DEFAULT);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ABS,
    ST_LHS,
    ST_NQ,
    ST_S2,
    ST_VAR,
    ST_RHS,
    ST_JUDGE,
    ST_UPD,
    ST_OUT
  } zad_state_e;

  typedef enum logic [1:0] {
    OP_LHS,
    OP_NQ,
    OP_S2,
    OP_RHS
  } zad_op_e;

  typedef struct packed {
    logic    accept;
    logic    load_abs;
    logic    mul_go;
    zad_op_e op;
    logic    load_var;
    logic    judge;
    logic    update;
    logic    publish;
  } zad_cmd_t;

  typedef struct packed {
    logic few;
    logic mul_busy;
    logic mul_done;
  } zad_sts_t;

endpackage

@@ sv/zad_mul.sv @@
`timescale 1ns / 1ps
// Serial unsigned multiplier: one DIG_W-bit digit of b per cycle, MSB digit first.
// Depends on zad_pkg.
module zad_mul #(
  parameter int A_W  = 48,
  parameter int B_W  = 32,
  parameter int P_W  = 80,
  parameter int DC_W = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [A_W-1:0]  a_i,
  input  logic [B_W-1:0]  b_i,
  input  logic [DC_W-1:0] ndig_i,
  output logic            busy_o,
  output logic            done_o,
  output logic [P_W-1:0]  prod_o
);
  import zad_pkg::*;

  logic                 busy_q;
  logic [DC_W-1:0]      left_q;
  logic [A_W-1:0]       a_q;
  logic [B_W-1:0]       b_q;
  logic [P_W-1:0]       acc_q;
  logic [DIG_W-1:0]     digit;
  logic [A_W+DIG_W-1:0] pp;

  assign digit = b_q[B_W-1 -: DIG_W];
  assign pp    = a_q * digit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      left_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      left_q <= ndig_i;
    end else if (busy_q) begin
      left_q <= left_q - DC_W'(1);
      if (left_q == DC_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= b_q << DIG_W;
      acc_q <= (acc_q << DIG_W) + P_W'(pp);
    end
  end

  assign busy_o = busy_q;
  assign done_o = busy_q && (left_q == DC_W'(1));
  assign prod_o = acc_q;

endmodule

@@ sv/zad_datapath.sv @@
`timescale 1ns / 1ps
// Datapath: sample ring, running sums, threshold, judging registers, result register.
// Depends on zad_pkg and zad_mul.
module zad_datapath #(
  parameter int WINDOW_DEPTH = zad_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = zad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  zad_pkg::zad_cmd_t             cmd_i,
  output zad_pkg::zad_sts_t             sts_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic                          cfg_valid_i,
  input  logic [zad_pkg::THR_W-1:0]     cfg_threshold_i,
  output logic                          is_anomaly_o,
  output logic [zad_pkg::HELD_W-1:0]    held_count_o
);
  import zad_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = SB + AW + 1;
  localparam int QW     = 2 * SB + AW;
  localparam int SQ_W   = 2 * SB;
  localparam int NX_W   = SB + CNT_W + 1;
  localparam int D_W    = SB + CNT_W + 2;
  localparam int AD_W   = SB + AW + 2;
  localparam int LHS_W  = 2 * AD_W;
  localparam int VAR_W  = QW + CNT_W;
  localparam int T2_W   = 2 * THR_W;
  localparam int K_AD   = (AD_W + DIG_W - 1) / DIG_W;
  localparam int K_N    = (CNT_W + DIG_W - 1) / DIG_W;
  localparam int K_S    = (SUM_W + DIG_W - 1) / DIG_W;
  localparam int K_T    = (T2_W + DIG_W - 1) / DIG_W;
  localparam int K_MAX  = (K_AD > K_T) ? K_AD : K_T;
  localparam int B_W    = K_MAX * DIG_W;
  localparam int A_W    = VAR_W;
  localparam int P_W    = A_W + B_W;
  localparam int DC_W   = $clog2(K_MAX + 1);
  localparam int SH_AD  = B_W - K_AD * DIG_W;
  localparam int SH_N   = B_W - K_N * DIG_W;
  localparam int SH_S   = B_W - K_S * DIG_W;
  localparam int SH_T   = B_W - K_T * DIG_W;

  // ring and running state
  logic signed [SB-1:0]    ring_mem [WINDOW_DEPTH];
  logic [AW-1:0]           wpos_q;
  logic [CNT_W-1:0]        cnt_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [QW-1:0]           sq_q;
  logic [T2_W-1:0]         t2_q;

  // per-item working registers
  logic signed [SB-1:0]    x_q;
  logic signed [SB-1:0]    old_q;
  logic [SQ_W-1:0]         xsq_q;
  logic [SQ_W-1:0]         oldsq_q;
  logic signed [NX_W-1:0]  nx_q;
  logic [AD_W-1:0]         ad_q;
  logic [LHS_W-1:0]        lhs_q;
  logic [VAR_W-1:0]        nq_q;
  logic [VAR_W-1:0]        var_q;
  logic [HELD_W-1:0]       held_q;
  logic                    flag_q;
  logic                    res_flag_q;
  logic [HELD_W-1:0]       res_held_q;

  logic signed [NX_W-1:0]  cnt_sx;
  logic signed [NX_W-1:0]  smp_sx;
  logic signed [NX_W-1:0]  nx_d;
  logic signed [SQ_W-1:0]  xw;
  logic signed [SQ_W-1:0]  ow;
  logic signed [SQ_W-1:0]  xsq_d;
  logic signed [SQ_W-1:0]  oldsq_d;
  logic signed [D_W-1:0]   dev;
  logic signed [D_W-1:0]   dev_abs;
  logic signed [SUM_W-1:0] sum_neg;
  logic [SUM_W-1:0]        sum_abs;
  logic                    full;
  logic [THR_W-1:0]        thr_sel;
  logic [P_W-1:0]          nq_x;
  logic [P_W-1:0]          diff;
  logic [P_W-1:0]          lhs_sh;

  logic [A_W-1:0]          mul_a;
  logic [B_W-1:0]          mul_b;
  logic [DC_W-1:0]         mul_nd;
  logic [P_W-1:0]          prod;
  logic                    mul_busy;
  logic                    mul_done;

  always_comb begin
    cnt_sx  = NX_W'($signed({1'b0, cnt_q}));
    smp_sx  = NX_W'(sample_i);
    nx_d    = cnt_sx * smp_sx;
    xw      = SQ_W'(sample_i);
    xsq_d   = xw * xw;
    ow      = SQ_W'(old_q);
    oldsq_d = ow * ow;
    dev     = D_W'(nx_q) - D_W'(sum_q);
    dev_abs = dev[D_W-1] ? -dev : dev;
    sum_neg = -sum_q;
    sum_abs = sum_q[SUM_W-1] ? sum_neg : sum_q;
    full    = (cnt_q == CNT_W'(WINDOW_DEPTH));
    thr_sel = (cfg_threshold_i == '0) ? THR_DEFAULT : cfg_threshold_i;
    nq_x    = P_W'(nq_q);
    diff    = nq_x - prod;
    lhs_sh  = P_W'(lhs_q) << FRAC_SH;
  end

  // operand select for the shared multiplier; b goes in MSB-aligned
  always_comb begin
    case (cmd_i.op)
      OP_LHS: begin
        mul_a  = A_W'(ad_q);
        mul_b  = B_W'(ad_q) << SH_AD;
        mul_nd = DC_W'(K_AD);
      end
      OP_NQ: begin
        mul_a  = A_W'(sq_q);
        mul_b  = B_W'(cnt_q) << SH_N;
        mul_nd = DC_W'(K_N);
      end
      OP_S2: begin
        mul_a  = A_W'(sum_abs);
        mul_b  = B_W'(sum_abs) << SH_S;
        mul_nd = DC_W'(K_S);
      end
      OP_RHS: begin
        mul_a  = var_q;
        mul_b  = B_W'(t2_q) << SH_T;
        mul_nd = DC_W'(K_T);
      end
      default: begin
        mul_a  = '0;
        mul_b  = '0;
        mul_nd = '0;
      end
    endcase
  end

  zad_mul #(
    .A_W (A_W),
    .B_W (B_W),
    .P_W (P_W),
    .DC_W(DC_W)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.mul_go),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .ndig_i (mul_nd),
    .busy_o (mul_busy),
    .done_o (mul_done),
    .prod_o (prod)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wpos_q <= '0;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
      t2_q   <= T2_DEFAULT;
      flag_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        t2_q <= T2_W'(thr_sel) * T2_W'(thr_sel);
      end
      if (cmd_i.accept) begin
        flag_q <= 1'b0;
      end else if (cmd_i.judge) begin
        flag_q <= lhs_sh > prod;
      end
      if (cmd_i.update) begin
        // drop the oldest sample once the ring is full
        sum_q <= sum_q + SUM_W'(x_q) - (full ? SUM_W'(old_q) : '0);
        sq_q  <= sq_q + QW'(xsq_q) - (full ? QW'(oldsq_q) : '0);
        if (!full) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
        wpos_q <= (wpos_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wpos_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    oldsq_q <= oldsq_d;
    if (cmd_i.accept) begin
      x_q    <= sample_i;
      xsq_q  <= xsq_d;
      nx_q   <= nx_d;
      held_q <= HELD_W'(cnt_q);
      old_q  <= ring_mem[wpos_q];
    end
    if (cmd_i.update) begin
      ring_mem[wpos_q] <= x_q;
    end
    if (cmd_i.load_abs) begin
      ad_q <= AD_W'(dev_abs);
    end
    // an NQ or S2 multiply start banks the previous product
    if (cmd_i.mul_go) begin
      case (cmd_i.op)
        OP_NQ:   lhs_q <= prod[LHS_W-1:0];
        OP_S2:   nq_q  <= prod[VAR_W-1:0];
        default: ;
      endcase
    end
    if (cmd_i.load_var) begin
      var_q <= (prod > nq_x) ? '0 : diff[VAR_W-1:0];
    end
    if (cmd_i.publish) begin
      res_flag_q <= flag_q;
      res_held_q <= held_q;
    end
  end

  assign sts_o.few      = (cnt_q < CNT_W'(2));
  assign sts_o.mul_busy = mul_busy;
  assign sts_o.mul_done = mul_done;

  assign is_anomaly_o = res_flag_q;
  assign held_count_o = res_held_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(WINDOW_DEPTH))
    else $error("sample count beyond window depth");

  a_wpos_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q < CNT_W'(WINDOW_DEPTH)) |-> (CNT_W'(wpos_q) == cnt_q))
    else $error("write position out of step with fill count");

  a_flag_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> $past(cmd_i.judge))
    else $error("anomaly flag set outside judge step");

endmodule

@@ sv/zad_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine: sequences the judging steps, the ring update and the output handshake.
// Depends on zad_pkg.
module zad_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  zad_pkg::zad_sts_t sts_i,
  output zad_pkg::zad_cmd_t cmd_o
);
  import zad_pkg::*;

  zad_state_e state_q;
  zad_state_e state_d;
  logic       out_valid_q;
  logic       out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // fewer than two held: skip judging, flag stays clear
          state_d = sts_i.few ? ST_UPD : ST_ABS;
        end
      end
      ST_ABS:   state_d = ST_LHS;
      ST_LHS:   if (sts_i.mul_done) state_d = ST_NQ;
      ST_NQ:    if (sts_i.mul_done) state_d = ST_S2;
      ST_S2:    if (sts_i.mul_done) state_d = ST_VAR;
      ST_VAR:   state_d = ST_RHS;
      ST_RHS:   if (sts_i.mul_done) state_d = ST_JUDGE;
      ST_JUDGE: state_d = ST_UPD;
      ST_UPD:   state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.op   = OP_LHS;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_ABS: cmd_o.load_abs = 1'b1;
      ST_LHS: begin
        cmd_o.op     = OP_LHS;
        cmd_o.mul_go = !sts_i.mul_busy;
      end
      ST_NQ: begin
        cmd_o.op     = OP_NQ;
        cmd_o.mul_go = !sts_i.mul_busy;
      end
      ST_S2: begin
        cmd_o.op     = OP_S2;
        cmd_o.mul_go = !sts_i.mul_busy;
      end
      ST_VAR: cmd_o.load_var = 1'b1;
      ST_RHS: begin
        cmd_o.op     = OP_RHS;
        cmd_o.mul_go = !sts_i.mul_busy;
      end
      ST_JUDGE: cmd_o.judge   = 1'b1;
      ST_UPD:   cmd_o.update  = 1'b1;
      ST_OUT:   cmd_o.publish = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");

  a_mul_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul_go |-> !sts_i.mul_busy)
    else $error("multiply started while multiplier busy");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && !out_ready_i) |=> (state_q == ST_OUT))
    else $error("finished item left before result register freed");

endmodule

@@ sv/zscore_anomaly_detector_top.sv @@
`timescale 1ns / 1ps
// Sliding-window z-score anomaly detector, top level.
// Depends on zad_pkg, zad_ctrl, zad_datapath (and zad_mul below it).
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/sample_i) takes one signed sample per
//   item. Each sample is judged against the samples already in the window and
//   then written into the ring. The output channel (out_valid_o/out_ready_i)
//   returns is_anomaly_o and held_count_o, the number of samples held before
//   this one, for every input item, in order.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the Q8.8 threshold; always
//   ready, a zero write loads 3.0. Write it only while the block is idle.
//   Sequencing: one item at a time. With the window holding two or more samples an
//   item goes through the absolute deviation, three products on the serial 16-bit
//   multiplier (deviation squared, n times the sum of squares, sum squared), the
//   spread, a fourth product (spread times threshold squared), the judge and the
//   ring update. With fewer than two samples held it skips judging and goes to the update.
//   The result sits in an output register, so the next item is accepted while
//   it waits; a stalled receiver holds up the following item at its last step.
//   Reset empties the window and restores the 3.0 threshold.
module zscore_anomaly_detector_top #(
  parameter int WINDOW_DEPTH = zad_pkg::WINDOW_DEPTH_DEF,
  parameter int SAMPLE_BITS  = zad_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_anomaly_o,
  output logic [zad_pkg::HELD_W-1:0]    held_count_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [zad_pkg::THR_W-1:0]     cfg_threshold_q8_8_i
);
  import zad_pkg::*;

  zad_cmd_t cmd;
  zad_sts_t sts;

  assign cfg_ready_o = 1'b1;

  zad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  zad_datapath #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_threshold_i(cfg_threshold_q8_8_i),
    .is_anomaly_o   (is_anomaly_o),
    .held_count_o   (held_count_o)
  );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for zscore_anomaly_detector_top: random and directed samples checked
// against an in-bench z-score predictor. Depends on zad_pkg and the detector RTL.
module tb_top;
  import zad_pkg::*;

  localparam int WIN         = WINDOW_DEPTH_DEF;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 240;
  localparam int HOLD_AT     = 400;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 20;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic              flag;
    logic [HELD_W-1:0] held;
  } verdict_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid = 1'b0;
  logic [15:0]          sample_in = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [THR_W-1:0]     cfg_thr = '0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 is_anomaly_o;
  logic [HELD_W-1:0]    held_count_o;
  logic                 cfg_ready_o;
  logic                 quiet = 1'b0;

  // predictor state
  logic signed [15:0]     window_samples [WIN];
  logic [$clog2(WIN)-1:0] wr_pos = '0;
  int unsigned            held_n = 0;
  longint                 win_sum = 0;
  longint                 win_sq = 0;
  logic [THR_W-1:0]       thr_model = THR_DEFAULT;

  verdict_t    verdicts_due[$];
  logic [15:0] samples_todo[$];
  int          items_queued = 0;
  int          samples_taken = 0;
  int          verdicts_seen = 0;
  int          flags_seen = 0;
  int          thr_writes = 0;
  int          errors = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        held_once = 1'b0;
  int          cycles = 0;

  zscore_anomaly_detector_top dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .sample_i            (sample_in),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .is_anomaly_o        (is_anomaly_o),
    .held_count_o        (held_count_o),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_threshold_q8_8_i(cfg_thr)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Judge x against the held samples, then push it into the ring.
  function automatic verdict_t score_sample(input logic signed [15:0] x);
    verdict_t     v;
    longint       xv;
    longint       dev;
    longint       old;
    logic [63:0]  adev;
    logic [63:0]  asum;
    logic [127:0] lhs;
    logic [127:0] nq;
    logic [127:0] s2;
    logic [127:0] spread;
    logic [127:0] rhs;
    xv = x;
    v.held = HELD_W'(held_n);
    v.flag = 1'b0;
    if (held_n >= 2) begin
      dev = longint'(held_n) * xv - win_sum;
      adev = (dev < 0) ? 64'(-dev) : 64'(dev);
      asum = (win_sum < 0) ? 64'(-win_sum) : 64'(win_sum);
      lhs = (128'(adev) * 128'(adev)) << FRAC_SH;
      nq = 128'(held_n) * 128'(win_sq);
      s2 = 128'(asum) * 128'(asum);
      spread = (nq < s2) ? 128'd0 : nq - s2;
      rhs = 128'(thr_model) * 128'(thr_model) * spread;
      v.flag = lhs > rhs;
    end
    if (held_n >= WIN) begin
      old = window_samples[wr_pos];
      win_sum -= old;
      win_sq -= old * old;
    end else begin
      held_n++;
    end
    window_samples[wr_pos] = x;
    win_sum += xv;
    win_sq += xv * xv;
    wr_pos++;
    return v;
  endfunction

  // Mostly noise around a center, some wider excursions, some full-range values.
  function automatic logic [15:0] draw_sample(input logic [15:0] center,
                                              input int unsigned spread);
    int unsigned pick;
    int          offs;
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      offs = int'($urandom_range(0, 2 * spread)) - int'(spread);
    end else if (pick < 92) begin
      offs = int'($urandom_range(0, 8 * spread + 8)) - int'(4 * spread + 4);
    end else begin
      return 16'($urandom);
    end
    return center + 16'(offs);
  endfunction

  function automatic void queue_sample(input logic [15:0] s);
    samples_todo.push_back(s);
    items_queued++;
  endfunction

  task automatic wait_drained();
    do @(posedge clk_i); while (verdicts_seen != items_queued);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_threshold(input logic [THR_W-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_thr <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    thr_model = (value == '0) ? THR_DEFAULT : value;
    thr_writes++;
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        verdicts_due.push_back(score_sample(sample_in));
        samples_taken++;
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
          gap_left <= $urandom_range(0, 9);
          in_valid <= 1'b0;
        end else if (samples_todo.size() != 0) begin
          in_valid <= 1'b1;
          sample_in <= samples_todo.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk_i) begin
    verdict_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        verdicts_seen++;
        if (is_anomaly_o) flags_seen++;
        if (verdicts_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, flag %0b held %0d", $time, is_anomaly_o,
                   held_count_o);
        end else begin
          want = verdicts_due.pop_front();
          if (is_anomaly_o !== want.flag) begin
            errors++;
            $display("%0t: is_anomaly expected %0b got %0b", $time, want.flag,
                     is_anomaly_o);
          end
          if (held_count_o !== want.held) begin
            errors++;
            $display("%0t: held_count expected %0d got %0d", $time, want.held,
                     held_count_o);
          end
        end
      end
      // one long hold-off lets the block back up into its input
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!held_once && verdicts_seen >= HOLD_AT) begin
        held_once <= 1'b1;
        hold_left <= HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(0, 9);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d items outstanding", $time, verdicts_due.size());
      $display("zscore_anomaly_detector_top test failed");
      $finish;
    end
  end

  initial begin
    logic [15:0] directed_samples [16];
    logic [15:0] phase_thr [PHASES];
    logic [15:0] center;
    int unsigned spread;
    directed_samples = '{16'd100, 16'd100, 16'd100, 16'd101, 16'd100, 16'd100,
                         16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF,
                         16'h8000, 16'h5555, 16'hAAAA, 16'd100};
    phase_thr = '{16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)), 16'd256,
                  16'($urandom_range(200, 1200)), THR_DEFAULT};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset threshold first: short window, zero variance, field extremes
    foreach (directed_samples[i]) queue_sample(directed_samples[i]);
    wait_drained();
    // zero falls back to the 3.0 default
    write_threshold('0);
    for (int i = 0; i < 6; i++) queue_sample(directed_samples[i + 9]);
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_threshold(phase_thr[ph]);
      if (ph == PHASES - 1) begin
        @(posedge clk_i);
        quiet <= 1'b1;
      end
      center = 16'($urandom);
      spread = ($urandom_range(0, 3) == 0) ? 0 : (1 << $urandom_range(0, 12));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // pause the sender once until every item has come back
        if (ph == 2 && k == PHASE_ITEMS / 2) wait_drained();
        queue_sample(draw_sample(center, spread));
      end
      wait_drained();
    end

    repeat (40) @(posedge clk_i);
    if (verdicts_due.size() != 0) begin
      errors++;
      $display("%0t: %0d items never arrived", $time, verdicts_due.size());
    end
    $display("Ran %0d samples through the window, %0d judged, %0d flagged,",
             samples_taken, verdicts_seen, flags_seen);
    $display("across %0d threshold writes including 0, 1 and 65535; %0d errors",
             thr_writes, errors);
    if (errors == 0) begin
      $display("zscore_anomaly_detector_top test passed");
    end else begin
      $display("zscore_anomaly_detector_top test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/zad_pkg.sv
sv/zad_mul.sv
sv/zad_datapath.sv
sv/zad_ctrl.sv
sv/zscore_anomaly_detector_top.sv
sim/tb_top.sv
